@@ rtl/pmsc_pkg.sv @@
// package: state codes, register indexes and fixed constants of the motor speed controller
`timescale 1ns / 1ps
`default_nettype none
package pmsc_pkg;

  // sequencer states, one-hot
  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DEN   = 13'b0000000000010,
    S_SDIV  = 13'b0000000000100,
    S_SPEED = 13'b0000000001000,
    S_ERR   = 13'b0000000010000,
    S_M0    = 13'b0000000100000,
    S_M1    = 13'b0000001000000,
    S_M2    = 13'b0000010000000,
    S_M3    = 13'b0000100000000,
    S_M4    = 13'b0001000000000,
    S_DRV   = 13'b0010000000000,
    S_DDIV  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  // configuration register indexes
  localparam logic [2:0] REG_TARGET_SPEED = 3'd0;
  localparam logic [2:0] REG_GAIN_P       = 3'd1;
  localparam logic [2:0] REG_GAIN_I       = 3'd2;
  localparam logic [2:0] REG_GAIN_D       = 3'd3;
  localparam logic [2:0] REG_CLOSED_LOOP  = 3'd4;
  localparam logic [2:0] REG_MANUAL_DUTY  = 3'd5;

  // 2*pi*1e6 (pi as 3.141592), 23 bits
  localparam logic [22:0] SPEED_NUM   = 23'd6283184;
  // 50 * 6
  localparam logic [40:0] SPEED_DEN   = 41'sd300;
  localparam logic [15:0] TICKS_PER_S = 16'd60;
  localparam logic [15:0] TICKS_SQ    = 16'd3600;
  localparam logic [23:0] SPEED_MAX   = 24'hFFFFFF;
  localparam logic [7:0]  DUTY_MAX    = 8'd255;

  // widths of the error path
  localparam int EW      = 34;  // wide error before saturation
  localparam int ERR_W   = 26;
  localparam int DIFF_W  = 27;
  localparam int SUM_W   = 40;
  localparam int MB_W    = 41;  // signed operand of the shared multiplier
  localparam int ACC_W   = 58;  // product and drive accumulator
  localparam int DEN_W   = 25;  // divisor width, 300 * 65535 fits

  localparam logic signed [EW-1:0]    ERR_MAX = 34'sd33554431;
  localparam logic signed [EW-1:0]    ERR_MIN = -34'sd33554432;
  localparam logic signed [SUM_W:0]   SUM_MAX = 41'sd549755813887;
  localparam logic signed [SUM_W:0]   SUM_MIN = -41'sd549755813888;

endpackage
`default_nettype wire

@@ rtl/pid_motor_speed_controller.sv @@
// top level: period-to-speed conversion and pid drive on one shared multiplier and divider
// a new item is taken only while idle, so each item is through and its result has
// moved into the output register before the next is accepted; most of the time goes
// to the speed divide. Closed loop skips the drive divide when the drive saturates or is
// not positive; open loop skips the pid steps; a zero period skips the speed divide
// rst (synchronous) clears pid state, loads register defaults and empties the output
`timescale 1ns / 1ps
`default_nettype none
module pid_motor_speed_controller #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] pulse_period,
  // result items
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       duty,
  output logic [23:0]      speed_q8,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import pmsc_pkg::*;

  // numerator of the speed divide and the quotient width it needs
  localparam int NUM_W = 23 + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [NUM_W-1:0] SPEED_NUM_Q = NUM_W'(SPEED_NUM) << FRAC_BITS;
  // drive divisor 60 * 2^F and the total at which the duty saturates
  localparam logic [DEN_W-1:0] DUTY_DEN = DEN_W'(TICKS_PER_S) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] DUTY_SAT = $signed(ACC_W'(DUTY_DEN) << 8);

  // configuration registers
  logic [15:0] target_speed;
  logic [15:0] gain_p;
  logic [15:0] gain_i;
  logic [15:0] gain_d;
  logic        closed_loop;
  logic [7:0]  manual_duty;

  // pid state
  logic signed [SUM_W-1:0] error_sum;
  logic signed [ERR_W-1:0] previous_error;

  // sequencer and working registers
  state_t                   state;
  logic [15:0]              period;
  logic [23:0]              speed;
  logic [7:0]               drive;
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;
  logic signed [MB_W-1:0]   term;   // scaled error or scaled difference
  logic signed [ACC_W-1:0]  acc;    // drive total

  // shared restoring divider: remainder, dividend shift line, quotient, divisor
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] dvd;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;

  // shared multiplier: 16-bit unsigned by 41-bit signed
  logic [15:0]             mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [ACC_W-1:0] prod;

  always_comb begin
    case (state)
      S_DEN: begin
        mul_a = period;
        mul_b = $signed(SPEED_DEN);
      end
      S_M0: begin
        mul_a = TICKS_PER_S;
        mul_b = MB_W'(err);
      end
      S_M1: begin
        mul_a = gain_p;
        mul_b = term;
      end
      S_M2: begin
        mul_a = TICKS_SQ;
        mul_b = MB_W'(diff);
      end
      S_M3: begin
        mul_a = gain_d;
        mul_b = term;
      end
      S_M4: begin
        mul_a = gain_i;
        mul_b = MB_W'(error_sum);
      end
      default: begin
        mul_a = 16'd0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = $signed({1'b0, mul_a}) * mul_b;

  // one divide step: shift in the next dividend bit, subtract when it fits
  logic [DEN_W:0] rs;
  logic [DEN_W:0] rs_sub;
  logic           take;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    rs       = {rem, dvd[NUM_W-1]};
    rs_sub   = rs - {1'b0, den};
    take     = rs >= {1'b0, den};
    rem_next = take ? rs_sub[DEN_W-1:0] : rs[DEN_W-1:0];
  end

  // error and integral, both saturated
  logic signed [EW-1:0]      err_wide;
  logic signed [ERR_W-1:0]   err_next;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   error_sum_next;

  always_comb begin
    err_wide = $signed(EW'(target_speed) << FRAC_BITS) - $signed(EW'(speed));
    if (err_wide > ERR_MAX) begin
      err_next = ERR_W'(ERR_MAX);
    end else if (err_wide < ERR_MIN) begin
      err_next = ERR_W'(ERR_MIN);
    end else begin
      err_next = ERR_W'(err_wide);
    end
    sum_wide = (SUM_W + 1)'(error_sum) + (SUM_W + 1)'(err_next);
    if (sum_wide > SUM_MAX) begin
      error_sum_next = SUM_W'(SUM_MAX);
    end else if (sum_wide < SUM_MIN) begin
      error_sum_next = SUM_W'(SUM_MIN);
    end else begin
      error_sum_next = SUM_W'(sum_wide);
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      target_speed   <= 16'd10;
      gain_p         <= 16'd5;
      gain_i         <= 16'd200;
      gain_d         <= 16'd0;
      closed_loop    <= 1'b1;
      manual_duty    <= 8'd0;
      error_sum      <= '0;
      previous_error <= '0;
    end else begin
      // register writes, unknown indexes fall through
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET_SPEED: target_speed <= cfg_data;
          REG_GAIN_P:       gain_p       <= cfg_data;
          REG_GAIN_I:       gain_i       <= cfg_data;
          REG_GAIN_D:       gain_d       <= cfg_data;
          REG_CLOSED_LOOP:  closed_loop  <= cfg_data[0];
          REG_MANUAL_DUTY:  manual_duty  <= cfg_data[7:0];
          default: ;
        endcase
      end

      // result handshake, the output register frees as soon as it is taken
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            period <= pulse_period;
            if (pulse_period == 16'd0) begin
              // no pulse: all-ones quotient saturates the speed
              quo   <= '1;
              state <= S_SPEED;
            end else begin
              state <= S_DEN;
            end
          end
        end
        S_DEN: begin
          // divisor 300 * period, then start the speed divide
          den   <= prod[DEN_W-1:0];
          rem   <= '0;
          dvd   <= SPEED_NUM_Q;
          quo   <= '0;
          cnt   <= CNT_W'(NUM_W);
          state <= S_SDIV;
        end
        S_SDIV: begin
          rem <= rem_next;
          dvd <= dvd << 1;
          quo <= {quo[NUM_W-2:0], take};
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= S_SPEED;
          end
        end
        S_SPEED: begin
          speed <= (quo > NUM_W'(SPEED_MAX)) ? SPEED_MAX : quo[23:0];
          if (closed_loop) begin
            state <= S_ERR;
          end else begin
            drive <= manual_duty;
            state <= S_DONE;
          end
        end
        S_ERR: begin
          err            <= err_next;
          diff           <= DIFF_W'(err_next) - DIFF_W'(previous_error);
          error_sum      <= error_sum_next;
          previous_error <= err_next;
          state          <= S_M0;
        end
        S_M0: begin
          term  <= MB_W'(prod);
          state <= S_M1;
        end
        S_M1: begin
          acc   <= prod;
          state <= S_M2;
        end
        S_M2: begin
          term  <= MB_W'(prod);
          state <= S_M3;
        end
        S_M3: begin
          acc   <= acc + prod;
          state <= S_M4;
        end
        S_M4: begin
          acc   <= acc + prod;
          state <= S_DRV;
        end
        S_DRV: begin
          if (acc <= 0) begin
            drive <= 8'd0;
            state <= S_DONE;
          end else if (acc >= DUTY_SAT) begin
            drive <= DUTY_MAX;
            state <= S_DONE;
          end else begin
            // total below 256 divisors: upper part seeds the remainder, 8 steps left
            den   <= DUTY_DEN;
            rem   <= acc[DEN_W+7:8];
            dvd   <= {acc[7:0], (NUM_W - 8)'(0)};
            quo   <= '0;
            cnt   <= CNT_W'(8);
            state <= S_DDIV;
          end
        end
        S_DDIV: begin
          rem <= rem_next;
          dvd <= dvd << 1;
          quo <= {quo[NUM_W-2:0], take};
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            drive <= {quo[6:0], take};
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output payload, loaded when the result moves into the output register
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      duty     <= drive;
      speed_q8 <= speed;
    end
  end

endmodule
`default_nettype wire

@@ dv/pid_drive_checker.sv @@
// checker: predicts the duty and speed of each control tick and compares them at the output
`timescale 1ns / 1ps
module pid_drive_checker #(
  parameter int FRAC = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] pulse_period,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  duty,
  input  logic [23:0] speed_q8,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          waiting,
  output int          checked,
  output int          clamp_hits,
  output int          mid_duties
);
  import pmsc_pkg::*;

  typedef struct packed {
    logic [7:0]  duty;
    logic [23:0] speed;
  } drive_t;

  localparam longint RAD_NUM  = 64'sd6283184;   // 2 * 3.141592 * 1e6
  localparam longint POLE_DEN = 64'sd300;       // 50 poles * 6
  localparam longint TICK_HZ  = 64'sd60;
  localparam longint ERR_HI   = 64'sd33554431;
  localparam longint ERR_LO   = -64'sd33554432;
  localparam longint SUM_HI   = 64'sd549755813887;
  localparam longint SUM_LO   = -64'sd549755813888;

  logic [15:0] ref_target, kp, ki, kd;
  logic        loop_on;
  logic [7:0]  man_duty;
  longint      integ_sum, last_err;
  drive_t      pending_drive[$];

  function automatic longint sat(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [23:0] period_speed(logic [15:0] period);
    longint q;
    if (period == 16'd0) return 24'hFFFFFF;
    q = (RAD_NUM << FRAC) / (POLE_DEN * longint'(period));
    return (q > 64'sd16777215) ? 24'hFFFFFF : q[23:0];
  endfunction

  // one control tick: speed always, pid state only in closed loop
  function automatic drive_t control_tick(logic [15:0] period);
    drive_t r;
    longint err, dlt, wide_sum, total, lvl;
    r.speed = period_speed(period);
    r.duty  = man_duty;
    if (loop_on) begin
      err = sat((longint'(ref_target) << FRAC) - longint'(r.speed), ERR_LO, ERR_HI);
      dlt = err - last_err;
      wide_sum = integ_sum + err;
      integ_sum = sat(wide_sum, SUM_LO, SUM_HI);
      if (integ_sum != wide_sum) clamp_hits++;
      last_err = err;
      total = TICK_HZ * longint'(kp) * err + longint'(ki) * integ_sum
            + TICK_HZ * TICK_HZ * longint'(kd) * dlt;
      lvl = total / (TICK_HZ << FRAC);
      if (total <= 0) r.duty = 8'd0;
      else if (lvl > 255) r.duty = 8'd255;
      else r.duty = lvl[7:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    drive_t want;
    if (rst) begin
      ref_target = 16'd10;
      kp         = 16'd5;
      ki         = 16'd200;
      kd         = 16'd0;
      loop_on    = 1'b1;
      man_duty   = 8'd0;
      integ_sum  = 0;
      last_err   = 0;
      mismatches = 0;
      checked    = 0;
      clamp_hits = 0;
      mid_duties = 0;
      pending_drive.delete();
    end else begin
      // retire the output first so an item taken on the same edge is not matched to it
      if (out_valid && out_ready) begin
        if (pending_drive.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual duty %0d speed %0d",
                   $time, duty, speed_q8);
        end else begin
          want = pending_drive.pop_front();
          checked++;
          if (want.duty != 8'd0 && want.duty != 8'd255) mid_duties++;
          if (duty !== want.duty) begin
            mismatches++;
            $display("%0t: duty mismatch, expected %0d, actual %0d", $time, want.duty, duty);
          end
          if (speed_q8 !== want.speed) begin
            mismatches++;
            $display("%0t: speed mismatch, expected %0d, actual %0d",
                     $time, want.speed, speed_q8);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET_SPEED: ref_target = cfg_data;
          REG_GAIN_P:       kp = cfg_data;
          REG_GAIN_I:       ki = cfg_data;
          REG_GAIN_D:       kd = cfg_data;
          REG_CLOSED_LOOP:  loop_on = cfg_data[0];
          REG_MANUAL_DUTY:  man_duty = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) pending_drive.push_back(control_tick(pulse_period));
    end
    waiting = pending_drive.size();
  end

endmodule

@@ dv/pid_motor_speed_controller_tb.sv @@
// testbench top: stimulus, handshake pacing and verdict for the motor speed controller
`timescale 1ns / 1ps
module pid_motor_speed_controller_tb;
  import pmsc_pkg::*;

  localparam int FRAC_BITS    = 8;
  localparam int RANDOM_ITEMS = 1100;
  localparam int HOLD_CYCLES  = 480;
  localparam int TAIL_CYCLES  = 64;
  // limit on run length, set well above the slowest correct run with gaps and stalls
  localparam int CYCLE_LIMIT  = 1000000;

  // indexes with no register behind them, writes there must change nothing
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_CHOKE} rx_mode_t;

  // block inputs, all known from time zero
  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic [15:0] pulse_period = 16'd0;
  logic        out_ready    = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic [2:0]  cfg_index    = 3'd0;
  logic [15:0] cfg_data     = 16'd0;

  // block outputs
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  duty;
  logic [23:0] speed_q8;
  logic        cfg_ready;

  // checker status
  int mismatches, waiting, checked, clamp_hits, mid_duties;

  // stimulus bookkeeping
  int          items_sent    = 0;
  int          cycle_count   = 0;
  int          burst_left    = 1;
  int          phase         = 0;
  logic        hold_req      = 1'b0;
  logic [15:0] target_now    = 16'd10;

  always #5 clk = ~clk;

  pid_motor_speed_controller #(
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pulse_period(pulse_period),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .duty(duty),
    .speed_q8(speed_q8),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  pid_drive_checker #(
    .FRAC(FRAC_BITS)
  ) drive_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pulse_period(pulse_period),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .duty(duty),
    .speed_q8(speed_q8),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .waiting(waiting),
    .checked(checked),
    .clamp_hits(clamp_hits),
    .mid_duties(mid_duties)
  );

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles with %0d results outstanding",
               $time, cycle_count, waiting);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random segments of free flow, coin flips, sparse and choked ready,
  // plus the long hold-off on request so the block backs up into its input
  initial begin : rx_side
    rx_mode_t mode;
    int seg;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      seg  = $urandom_range(16, 160);
      repeat (seg) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end else if (mode == RX_FREE) begin
          out_ready <= 1'b1;
        end else begin
          case (mode)
            RX_COIN:   out_ready <= ($urandom_range(0, 1) == 0);
            RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default:   out_ready <= ($urandom_range(0, 9) >= 8);
          endcase
        end
      end
    end
  end

  // one config write, valid stays up for a following write in the same step
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    if (idx == REG_TARGET_SPEED) target_now = val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // offer one item and hold it until the block takes it
  task automatic offer(logic [15:0] p);
    pulse_period <= p;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // wait until every predicted result has come out
  task automatic wait_drained();
    do @(posedge clk); while (waiting != 0);
  endtask

  // periods: mostly near the current set point so the loop sits off the rails,
  // the rest full range, tiny, top end and the occasional missing pulse
  function automatic logic [15:0] pick_period();
    int base;
    logic [15:0] r;
    case ($urandom_range(0, 19))
      0:       r = 16'd0;
      1:       r = 16'($urandom_range(1, 8));
      2:       r = 16'hFFFF - 16'($urandom_range(0, 3));
      3, 4, 5, 6, 7: r = 16'($urandom);
      default: begin
        base = (target_now == 16'd0) ? 65535 : 20944 / target_now;
        base = base * $urandom_range(70, 130) / 100;
        r = (base > 65535) ? 16'hFFFF : 16'(base);
      end
    endcase
    return r;
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 63));
      3:       return 16'($urandom_range(0, 2047));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_target();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(1, 400));
      default: return 16'($urandom);
    endcase
  endfunction

  // new random tuning between phases, block is idle here
  task automatic retune();
    if ($urandom_range(0, 1)) write_reg(REG_TARGET_SPEED, pick_target());
    if ($urandom_range(0, 1)) write_reg(REG_GAIN_P, pick_gain());
    if ($urandom_range(0, 1)) write_reg(REG_GAIN_I, pick_gain());
    if ($urandom_range(0, 1)) write_reg(REG_GAIN_D, pick_gain());
    if ($urandom_range(0, 5) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
    if ($urandom_range(0, 2) == 0)
      write_reg(REG_CLOSED_LOOP, {15'($urandom), ($urandom_range(0, 3) != 0)});
    if ($urandom_range(0, 2) == 0) write_reg(REG_MANUAL_DUTY, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // a run of items in bursts; gaps up to a whole tick so idle time lands on every
  // stage of the divide and multiply sequence
  task automatic send_run(int n, bit gapless, bit no_pulse);
    int gap;
    for (int i = 0; i < n; i++) begin
      offer(no_pulse ? 16'd0 : pick_period());
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 12);
        gap = (gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
        if (gap > 0 && i < n - 1) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int done_items;
    int run_len;
    logic [15:0] probe_periods [9];
    probe_periods = '{16'd0, 16'd1, 16'd2, 16'd300, 16'd1000, 16'd20944,
                      16'h5555, 16'hAAAA, 16'hFFFF};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset tuning: missing pulse (speed ceiling), shortest and longest periods,
    // alternating bit patterns
    foreach (probe_periods[i]) offer(probe_periods[i]);
    in_valid <= 1'b0;
    wait_drained();

    // top proportional and derivative gains, no integral, high set point: drive hits the
    // rails, derivative swings both ways as the period jumps
    write_reg(REG_TARGET_SPEED, 16'hFFFF);
    write_reg(REG_GAIN_P, 16'hFFFF);
    write_reg(REG_GAIN_I, 16'd0);
    write_reg(REG_GAIN_D, 16'hFFFF);
    cfg_valid <= 1'b0;
    offer(16'hFFFF);
    offer(16'd1);
    offer(16'd0);
    in_valid <= 1'b0;
    wait_drained();

    // set point zero: error negative, drive at or below zero
    write_reg(REG_TARGET_SPEED, 16'd0);
    write_reg(REG_GAIN_I, 16'hFFFF);
    write_reg(REG_GAIN_D, 16'd0);
    cfg_valid <= 1'b0;
    offer(16'd0);
    offer(16'hFFFF);
    in_valid <= 1'b0;
    wait_drained();

    // open loop: only bit 0 of the mode word counts, duty from the manual register,
    // speed still reported and pid state left alone
    write_reg(REG_CLOSED_LOOP, 16'hFFFE);
    write_reg(REG_MANUAL_DUTY, 16'hFFFF);
    cfg_valid <= 1'b0;
    offer(16'd0);
    offer(16'hFFFF);
    in_valid <= 1'b0;
    wait_drained();

    // writes to unused indexes must not disturb anything
    write_reg(REG_MANUAL_DUTY, 16'h0100);
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h0000);
    cfg_valid <= 1'b0;
    offer(16'd1234);
    in_valid <= 1'b0;
    wait_drained();

    // back to closed loop with the state left from before the open-loop ticks
    write_reg(REG_CLOSED_LOOP, 16'h0001);
    write_reg(REG_TARGET_SPEED, 16'd10);
    write_reg(REG_GAIN_P, 16'd5);
    write_reg(REG_GAIN_I, 16'd200);
    cfg_valid <= 1'b0;
    offer(16'd2094);
    offer(16'd2000);
    in_valid <= 1'b0;
    wait_drained();

    // random phases, each ends fully drained so tuning only changes while idle;
    // two phases start with the long result-side hold-off
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      run_len = $urandom_range(20, 60);
      retune();
      if (phase == 3 || phase == 14) hold_req = 1'b1;
      send_run(run_len, 1'b0, 1'b0);
      done_items += run_len;
      wait_drained();
      phase++;
    end

    // let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d items in %0d random tuning phases plus directed runs,",
             items_sent, phase);
    $display("%0d results checked, integrator clamped on %0d ticks, %0d duties off the rails",
             checked, clamp_hits, mid_duties);
    if (mismatches == 0 && waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pmsc_pkg.sv
rtl/pid_motor_speed_controller.sv
dv/pid_drive_checker.sv
dv/pid_motor_speed_controller_tb.sv
